@@ hdl/grpc_pkg.sv @@
// ----------------------------------------------------------------------------
// grpc_pkg
// Shared constants, register codes and types of the golden ratio palette block.
// ----------------------------------------------------------------------------
package grpc_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int HUE_BITS_DEF   = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CH_W           = 8;

  // golden ratio fraction with 32 fraction bits
  localparam logic [63:0] GOLD32 = 64'h0000_0000_9E37_79B9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HUE   = 2'd0,
    REG_SATURATION  = 2'd1,
    REG_VALUE_LEVEL = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] START_HUE_RST   = 16'd0;
  localparam logic [CFG_W-1:0] SATURATION_RST  = 16'd32768;
  localparam logic [CFG_W-1:0] VALUE_LEVEL_RST = 16'd62259;

  typedef struct packed {
    logic [CFG_W-1:0] start_hue;
    logic [CFG_W-1:0] saturation;
    logic [CFG_W-1:0] value_level;
  } cfg_vals_t;

  // hsv sectors, named by the hue range they cover
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // golden ratio step rounded to hb fraction bits
  function automatic logic [23:0] golden_step(input int hb);
    logic [63:0] r;
    r = ((GOLD32 << hb) + 64'h0000_0000_8000_0000) >> 32;
    return r[23:0];
  endfunction

endpackage

@@ hdl/grpc_channels.sv @@
// ----------------------------------------------------------------------------
// grpc_channels
// Valid/ready channel interfaces for index input, color output and config.
// ----------------------------------------------------------------------------
interface grpc_in_if #(
  parameter int INDEX_BITS = grpc_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] palette_index;

  modport source(output valid, output palette_index, input ready);
  modport sink(input valid, input palette_index, output ready);
endinterface

interface grpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [grpc_pkg::CH_W-1:0] red;
  logic [grpc_pkg::CH_W-1:0] green;
  logic [grpc_pkg::CH_W-1:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface grpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [grpc_pkg::CFG_IDX_W-1:0] index;
  logic [grpc_pkg::CFG_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ hdl/grpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// grpc_cfg_regs
// Start hue, saturation and value registers behind the config write channel.
// ----------------------------------------------------------------------------
module grpc_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  grpc_cfg_if.sink            cfg_chan,
  output grpc_pkg::cfg_vals_t cfg
);

  grpc_pkg::cfg_vals_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_hue   <= grpc_pkg::START_HUE_RST;
      cfg_r.saturation  <= grpc_pkg::SATURATION_RST;
      cfg_r.value_level <= grpc_pkg::VALUE_LEVEL_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (grpc_pkg::cfg_reg_t'(cfg_chan.index))
        grpc_pkg::REG_START_HUE:   cfg_r.start_hue   <= cfg_chan.data;
        grpc_pkg::REG_SATURATION:  cfg_r.saturation  <= cfg_chan.data;
        grpc_pkg::REG_VALUE_LEVEL: cfg_r.value_level <= cfg_chan.data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/grpc_hue_stages.sv @@
// ----------------------------------------------------------------------------
// grpc_hue_stages
// Three stages: golden ratio product, hue sum, sector and fraction split.
// ----------------------------------------------------------------------------
module grpc_hue_stages #(
  parameter int INDEX_BITS = grpc_pkg::INDEX_BITS_DEF,
  parameter int HUE_BITS   = grpc_pkg::HUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [INDEX_BITS-1:0]      in_index,
  input  logic [grpc_pkg::CFG_W-1:0] start_hue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output grpc_pkg::sector_t          out_sector,
  output logic [HUE_BITS-1:0]        out_frac,
  output logic [1:0]                 out_shade
);

  localparam int GW = INDEX_BITS - 2;
  localparam int WW = (GW > HUE_BITS) ? GW : HUE_BITS;
  localparam logic [23:0] STEP_FULL = grpc_pkg::golden_step(HUE_BITS);
  localparam logic [HUE_BITS-1:0] STEP = STEP_FULL[HUE_BITS-1:0];

  logic                  v1_r, v2_r, v3_r;
  logic                  en1, en2, en3;
  logic [WW-1:0]         grp_w;
  logic [HUE_BITS-1:0]   grp1;
  logic [2*HUE_BITS-1:0] mul;
  logic [HUE_BITS+15:0]  base_w;
  logic [HUE_BITS+2:0]   h6;
  logic [HUE_BITS-1:0]   prod1_r, hue2_r, frac3_r;
  logic [1:0]            shade1_r, shade2_r, shade3_r;
  grpc_pkg::sector_t     sector3_r;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // group + 1, times the step, modulo one
  assign grp_w  = WW'(in_index[INDEX_BITS-1:2]) + WW'(1);
  assign grp1   = grp_w[HUE_BITS-1:0];
  assign mul    = grp1 * STEP;
  assign base_w = {start_hue, {HUE_BITS{1'b0}}};
  assign h6     = {1'b0, hue2_r, 2'b00} + {2'b00, hue2_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod1_r  <= mul[HUE_BITS-1:0];
      shade1_r <= in_index[1:0];
    end
    if (en2) begin
      hue2_r   <= base_w[HUE_BITS+15:16] + prod1_r;
      shade2_r <= shade1_r;
    end
    if (en3) begin
      sector3_r <= grpc_pkg::sector_t'(h6[HUE_BITS+2:HUE_BITS]);
      frac3_r   <= h6[HUE_BITS-1:0];
      shade3_r  <= shade2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_sector = sector3_r;
  assign out_frac   = frac3_r;
  assign out_shade  = shade3_r;

  // six times a fraction below one never reaches sector six
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (sector3_r <= grpc_pkg::SEC_MR))
    else $error("hue sector out of range");

endmodule

@@ hdl/grpc_hsv_stages.sv @@
// ----------------------------------------------------------------------------
// grpc_hsv_stages
// Five stages: hsv products, differences, split wide multiplies, sector select, shading.
// ----------------------------------------------------------------------------
module grpc_hsv_stages #(
  parameter int HUE_BITS = grpc_pkg::HUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  grpc_pkg::sector_t         in_sector,
  input  logic [HUE_BITS-1:0]       in_frac,
  input  logic [1:0]                in_shade,
  input  grpc_pkg::cfg_vals_t       cfg,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [grpc_pkg::CH_W-1:0] red,
  output logic [grpc_pkg::CH_W-1:0] green,
  output logic [grpc_pkg::CH_W-1:0] blue
);

  localparam int XW = HUE_BITS + 17;
  localparam logic [XW-1:0] FULL = {1'b1, {(HUE_BITS+16){1'b0}}};
  localparam logic [HUE_BITS:0] ONE = {1'b1, {HUE_BITS{1'b0}}};

  function automatic logic [7:0] sat9(input logic [8:0] x);
    return x[8] ? 8'hFF : x[7:0];
  endfunction

  logic [15:0] s, v;
  assign s = cfg.saturation;
  assign v = cfg.value_level;

  logic v4_r, v5_r, v6_r, v7_r, v8_r;
  logic en4, en5, en6, en7, en8;

  assign en8      = !v8_r || out_ready;
  assign en7      = !v7_r || en8;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign in_ready = en4;

  // stage 4 products
  logic [HUE_BITS:0]    one_minus_f;
  logic [HUE_BITS+15:0] fs_nxt, fs4_r;
  logic [HUE_BITS+16:0] gs_nxt, gs4_r;
  logic [32:0]          pv_nxt, pv4_r;

  assign one_minus_f = ONE - {1'b0, in_frac};
  assign fs_nxt      = in_frac * s;
  assign gs_nxt      = one_minus_f * s;
  assign pv_nxt      = v * (17'h1_0000 - {1'b0, s});

  // stage 5 differences
  logic [XW-1:0] xq5_r, xt5_r;
  logic [7:0]    pb5_r, pb6_r, pb7_r;

  // stage 6 partial products
  logic [HUE_BITS+16:0] qhi6_r, thi6_r;
  logic [31:0]          qlo6_r, tlo6_r;

  // stage 7 sums and sector select
  logic [HUE_BITS+32:0] qsum, tsum;
  logic [7:0]           qb, tb, vb;
  logic [7:0]           r_nxt, g_nxt, b_nxt;
  logic [7:0]           r7_r, g7_r, b7_r;

  assign qsum = {qhi6_r, 16'h0000} + {{(HUE_BITS+1){1'b0}}, qlo6_r};
  assign tsum = {thi6_r, 16'h0000} + {{(HUE_BITS+1){1'b0}}, tlo6_r};
  assign qb   = sat9(qsum[HUE_BITS+32:HUE_BITS+24]);
  assign tb   = sat9(tsum[HUE_BITS+32:HUE_BITS+24]);
  assign vb   = v[15:8];

  grpc_pkg::sector_t sector4_r, sector5_r, sector6_r;
  logic [1:0]        shade4_r, shade5_r, shade6_r, shade7_r;

  always_comb begin
    unique case (sector6_r)
      grpc_pkg::SEC_RY: begin r_nxt = vb; g_nxt = tb; b_nxt = pb6_r; end
      grpc_pkg::SEC_YG: begin r_nxt = qb; g_nxt = vb; b_nxt = pb6_r; end
      grpc_pkg::SEC_GC: begin r_nxt = pb6_r; g_nxt = vb; b_nxt = tb; end
      grpc_pkg::SEC_CB: begin r_nxt = pb6_r; g_nxt = qb; b_nxt = vb; end
      grpc_pkg::SEC_BM: begin r_nxt = tb; g_nxt = pb6_r; b_nxt = vb; end
      default:          begin r_nxt = vb; g_nxt = pb6_r; b_nxt = qb; end
    endcase
  end

  // stage 8 shade scaling by (4 - k) / 4
  logic [2:0]  mulk;
  logic [10:0] rs, gsc, bs;
  logic [7:0]  red_r, green_r, blue_r;

  assign mulk = 3'd4 - {1'b0, shade7_r};
  assign rs   = r7_r * mulk;
  assign gsc  = g7_r * mulk;
  assign bs   = b7_r * mulk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      fs4_r     <= fs_nxt;
      gs4_r     <= gs_nxt;
      pv4_r     <= pv_nxt;
      sector4_r <= in_sector;
      shade4_r  <= in_shade;
    end
    if (en5) begin
      xq5_r     <= FULL - {1'b0, fs4_r};
      xt5_r     <= FULL - gs4_r;
      pb5_r     <= sat9(pv4_r[32:24]);
      sector5_r <= sector4_r;
      shade5_r  <= shade4_r;
    end
    if (en6) begin
      qhi6_r    <= v * xq5_r[XW-1:16];
      qlo6_r    <= v * xq5_r[15:0];
      thi6_r    <= v * xt5_r[XW-1:16];
      tlo6_r    <= v * xt5_r[15:0];
      pb6_r     <= pb5_r;
      sector6_r <= sector5_r;
      shade6_r  <= shade5_r;
    end
    if (en7) begin
      r7_r     <= r_nxt;
      g7_r     <= g_nxt;
      b7_r     <= b_nxt;
      pb7_r    <= pb6_r;
      shade7_r <= shade6_r;
    end
    if (en8) begin
      red_r   <= rs[9:2];
      green_r <= gsc[9:2];
      blue_r  <= bs[9:2];
    end
  end

  assign out_valid = v8_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  // q and t products stay below one byte of range
  a_no_channel_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (!qsum[HUE_BITS+32] && !tsum[HUE_BITS+32]))
    else $error("hsv channel overflow");

  // a stage only holds while its successor is full
  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && !en7) |-> (v8_r && !out_ready))
    else $error("stage held without downstream stall");

  // keeps the spare p byte copy in step with stage 7
  a_p_byte_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && en7) |=> (pb7_r == $past(pb6_r)))
    else $error("p byte lost between stages");

endmodule

@@ hdl/golden_ratio_palette_color.sv @@
// ----------------------------------------------------------------------------
// golden_ratio_palette_color
// Palette index to RGB color: golden ratio hue per group of four, hsv to rgb,
// four shades per hue.
//
//   channel    dir   payload                          width
//   in_chan    in    palette_index                    INDEX_BITS
//   out_chan   out   red, green, blue                 8 each
//   cfg_chan   in    index, data (start_hue, sat, v)  2, 16
//
// one transaction per cycle while the output is ready, through the three hue
// stages and five hsv stages (multiplier stages set the depth)
// synchronous active-low reset clears valid bits and loads register defaults
// each stage holds only while the stage after it is full and stalled, so
// bubbles close up and a stalled output never loses or repeats a transaction
// ----------------------------------------------------------------------------
module golden_ratio_palette_color #(
  parameter int INDEX_BITS = grpc_pkg::INDEX_BITS_DEF,
  parameter int HUE_BITS   = grpc_pkg::HUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  grpc_in_if.sink     in_chan,
  grpc_out_if.source  out_chan,
  grpc_cfg_if.sink    cfg_chan
);

  grpc_pkg::cfg_vals_t cfg;
  logic                hue_valid;
  logic                hue_ready;
  grpc_pkg::sector_t   hue_sector;
  logic [HUE_BITS-1:0] hue_frac;
  logic [1:0]          hue_shade;

  grpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  grpc_hue_stages #(
    .INDEX_BITS (INDEX_BITS),
    .HUE_BITS   (HUE_BITS)
  ) u_hue_stages (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_index   (in_chan.palette_index),
    .start_hue  (cfg.start_hue),
    .out_valid  (hue_valid),
    .out_ready  (hue_ready),
    .out_sector (hue_sector),
    .out_frac   (hue_frac),
    .out_shade  (hue_shade)
  );

  grpc_hsv_stages #(
    .HUE_BITS (HUE_BITS)
  ) u_hsv_stages (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hue_valid),
    .in_ready  (hue_ready),
    .in_sector (hue_sector),
    .in_frac   (hue_frac),
    .in_shade  (hue_shade),
    .cfg       (cfg),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .red       (out_chan.red),
    .green     (out_chan.green),
    .blue      (out_chan.blue)
  );

  // input backpressure only when every stage is full and the output stalls
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled with room in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid right after reset");

endmodule

@@ verif/tb_golden_ratio_palette_color.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_golden_ratio_palette_color
// Drives palette indices through the golden ratio palette block under several
// saturation, value and start hue settings and checks every RGB transaction
// against a bit-exact fixed-point hsv model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_golden_ratio_palette_color;

  localparam logic [grpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [63:0] GOLD_STEP_W =
    ((grpc_pkg::GOLD32 << grpc_pkg::HUE_BITS_DEF) + 64'h8000_0000) >> 32;
  localparam logic [15:0] GOLD_STEP = GOLD_STEP_W[15:0];
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int NUM_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 116;

  typedef struct packed {
    logic [grpc_pkg::CH_W-1:0] red;
    logic [grpc_pkg::CH_W-1:0] green;
    logic [grpc_pkg::CH_W-1:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst_n;

  grpc_in_if #(.INDEX_BITS(grpc_pkg::INDEX_BITS_DEF)) in_chan ();
  grpc_out_if  out_chan ();
  grpc_cfg_if  cfg_chan ();

  golden_ratio_palette_color #(
    .INDEX_BITS(grpc_pkg::INDEX_BITS_DEF),
    .HUE_BITS  (grpc_pkg::HUE_BITS_DEF)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  logic [grpc_pkg::CFG_W-1:0] hue_origin = grpc_pkg::START_HUE_RST;
  logic [grpc_pkg::CFG_W-1:0] sat_frac   = grpc_pkg::SATURATION_RST;
  logic [grpc_pkg::CFG_W-1:0] val_frac   = grpc_pkg::VALUE_LEVEL_RST;

  logic [grpc_pkg::INDEX_BITS_DEF-1:0] pending_indices [$];
  color_t                              expected_colors [$];
  int  mismatch_count  = 0;
  int  src_idle        = 0;
  int  sink_hold       = 0;
  logic bursts_on      = 1'b1;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [63:0] clamp_byte(input logic [63:0] x);
    return (x > 64'd255) ? 64'd255 : x;
  endfunction

  function automatic color_t palette_color(input logic [grpc_pkg::INDEX_BITS_DEF-1:0] idx);
    logic [31:0] hue_sum;
    logic [18:0] h6;
    logic [63:0] f, s, v, vb, pb, qb, tb;
    logic [63:0] ch [3];
    logic [63:0] weight;
    color_t c;
    hue_sum = 32'(hue_origin) + (32'(idx >> 2) + 32'd1) * 32'(GOLD_STEP);
    h6 = 19'(hue_sum[15:0]) * 19'd6;
    f = 64'(h6[15:0]);
    s = 64'(sat_frac);
    v = 64'(val_frac);
    vb = clamp_byte(v >> 8);
    pb = clamp_byte((v * (64'd65536 - s)) >> 24);
    qb = clamp_byte((v * ((64'd1 << 32) - f * s)) >> 40);
    tb = clamp_byte((v * ((64'd1 << 32) - (64'd65536 - f) * s)) >> 40);
    case (grpc_pkg::sector_t'(h6[18:16]))
      grpc_pkg::SEC_RY: ch = '{vb, tb, pb};
      grpc_pkg::SEC_YG: ch = '{qb, vb, pb};
      grpc_pkg::SEC_GC: ch = '{pb, vb, tb};
      grpc_pkg::SEC_CB: ch = '{pb, qb, vb};
      grpc_pkg::SEC_BM: ch = '{tb, pb, vb};
      default:          ch = '{vb, pb, qb};
    endcase
    // shade scales by (4 - k) / 4
    weight = 64'd4 - 64'(idx[1:0]);
    c.red   = 8'((ch[0] * weight) >> 2);
    c.green = 8'((ch[1] * weight) >> 2);
    c.blue  = 8'((ch[2] * weight) >> 2);
    return c;
  endfunction

  // index driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.palette_index <= '0;
      src_idle <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_colors.push_back(palette_color(in_chan.palette_index));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (src_idle > 0) begin
          in_chan.valid <= 1'b0;
          src_idle <= src_idle - 1;
        end else if (pending_indices.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 4) == 0) begin
          in_chan.valid <= 1'b0;
          src_idle <= $urandom_range(0, 4);
        end else begin
          in_chan.valid <= 1'b1;
          in_chan.palette_index <= pending_indices.pop_front();
        end
      end
    end
  end

  // color receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      out_chan.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_chan.ready <= 1'b0;
      sink_hold <= LONG_HOLD_CYCLES - 1;
      long_hold_done <= 1'b1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      sink_hold <= $urandom_range(0, 4);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // color checker
  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected color transaction r=%0d g=%0d b=%0d",
                   out_chan.red, out_chan.green, out_chan.blue);
      end else begin
        want = expected_colors.pop_front();
        if (out_chan.red !== want.red || out_chan.green !== want.green ||
            out_chan.blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue,
                     out_chan.red, out_chan.green, out_chan.blue);
        end
      end
    end
  end

  task automatic write_reg(input logic [grpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [grpc_pkg::CFG_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      grpc_pkg::REG_START_HUE:   hue_origin = val;
      grpc_pkg::REG_SATURATION:  sat_frac   = val;
      grpc_pkg::REG_VALUE_LEVEL: val_frac   = val;
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // sampled away from the rising edge so queue and valid updates have settled
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_indices.size() != 0 || in_chan.valid || expected_colors.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [grpc_pkg::INDEX_BITS_DEF-1:0] directed_idx [21] = '{
      16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006,
      16'h0007, 16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF, 16'h7FFF, 16'h8000,
      16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234
    };
    logic [grpc_pkg::CFG_W-1:0] settings [NUM_SETTINGS][3];
    logic [grpc_pkg::INDEX_BITS_DEF-1:0] idx;

    rst_n <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= '0;
    cfg_chan.data  <= '0;

    settings[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    settings[1] = '{16'h0000, 16'h0000, 16'h0000};
    settings[2] = '{16'h0000, 16'hFFFF, 16'hFFFF};
    settings[3] = '{16'h8000, 16'h0001, 16'h8000};
    settings[4] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    settings[5] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    settings[6] = '{16'hFFFF, 16'h0000, 16'hFFFF};
    settings[7] = '{grpc_pkg::START_HUE_RST, grpc_pkg::SATURATION_RST,
                    grpc_pkg::VALUE_LEVEL_RST};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, field extremes and every shade
    foreach (directed_idx[i]) pending_indices.push_back(directed_idx[i]);
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_reg(grpc_pkg::REG_START_HUE,   settings[p][0]);
      write_reg(grpc_pkg::REG_SATURATION,  settings[p][1]);
      write_reg(grpc_pkg::REG_VALUE_LEVEL, settings[p][2]);
      // write to an unmapped register index must be ignored
      if (p == 4) write_reg(REG_UNUSED, 16'($urandom));
      if (p == NUM_SETTINGS - 1) bursts_on <= 1'b0;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        case ($urandom_range(0, 7))
          0:       idx = 16'($urandom_range(0, 15));
          1:       idx = 16'(32'hFFFF - $urandom_range(0, 15));
          default: idx = 16'($urandom_range(0, 16'hFFFF));
        endcase
        pending_indices.push_back(idx);
      end
      // receiver holds off while the sender keeps offering
      if (p == 0) long_hold_req <= 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("** golden_ratio_palette_color: PASSED **");
    else
      $display("** golden_ratio_palette_color: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** golden_ratio_palette_color: FAILED **");
    $finish;
  end

endmodule
